/* rtl/best_divisor_select_core_assert.svh */
// ----------------------------------------------------------------------------
// best_divisor_select_core_assert.svh
// Assertion macros used by the checker file of the divisor selector.
// ----------------------------------------------------------------------------
`ifndef BEST_DIVISOR_SELECT_CORE_ASSERT_SVH
`define BEST_DIVISOR_SELECT_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define BDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// Widths, codes, types and scoring helpers of the divisor selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

	localparam int unsigned TT_W    = 64;
	localparam int unsigned WGT_W   = 4;
	localparam int unsigned IDX_W   = 24;
	localparam int unsigned COST_W  = 11;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned APB_W   = 64;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned N_CHECK = 4;

	// register select is paddr bit 3 (8-byte stride)
	localparam logic REG_OFF_SET = 1'b0;
	localparam logic REG_ON_SET  = 1'b1;

	typedef logic signed [COST_W-1:0] cost_t;

	localparam cost_t COST_NONE = -11'sd1;
	localparam logic [COST_W-1:0] WGT_BONUS_BASE = 11'd80;

	localparam logic [TT_W-1:0] POP_M1  = 64'h5555555555555555;
	localparam logic [TT_W-1:0] POP_M2  = 64'h3333333333333333;
	localparam logic [TT_W-1:0] POP_M4  = 64'h0F0F0F0F0F0F0F0F;
	localparam logic [TT_W-1:0] POP_M8  = 64'h00FF00FF00FF00FF;
	localparam logic [TT_W-1:0] POP_M16 = 64'h0000FFFF0000FFFF;

	// one candidate after scoring: best passing check of one divisor
	typedef struct packed {
		logic              last;
		logic              ok;
		cost_t             score;
		logic [TT_W-1:0]   fn;
		logic [IDX_W-1:0]  index;
		logic [WGT_W-1:0]  weight;
	} cand_t;

	function automatic logic [CNT_W-1:0] pop64(input logic [TT_W-1:0] t);
		logic [TT_W-1:0] a;
		a = (t & POP_M1) + ((t >> 1) & POP_M1);
		a = (a & POP_M2) + ((a >> 2) & POP_M2);
		a = (a & POP_M4) + ((a >> 4) & POP_M4);
		a = (a & POP_M8) + ((a >> 8) & POP_M8);
		a = (a & POP_M16) + ((a >> 16) & POP_M16);
		return CNT_W'(a[31:0] + a[63:32]);
	endfunction

	// 7*n + 10*(8-w), or -1 when nothing is covered
	function automatic cost_t score_of(input logic [CNT_W-1:0] n,
			input logic [WGT_W-1:0] w);
		logic [COST_W-1:0] n_ext;
		logic [COST_W-1:0] w_ext;
		logic [COST_W-1:0] n7;
		logic [COST_W-1:0] w10;
		n_ext = COST_W'(n);
		w_ext = COST_W'(w);
		n7    = (n_ext << 3) - n_ext;
		w10   = (w_ext << 3) + (w_ext << 1);
		if (n == '0) begin
			return COST_NONE;
		end
		return cost_t'(n7 + WGT_BONUS_BASE - w10);
	endfunction

endpackage

`default_nettype wire

/* rtl/bds_in_if.sv */
// ----------------------------------------------------------------------------
// bds_in_if
// Divisor channel: one candidate truth table with weight and end-of-scan mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bds_in_if import bds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TT_W-1:0]  divisor;
	logic [WGT_W-1:0] weight;
	logic             last;

	modport source (output valid, divisor, weight, last, input ready);
	modport sink   (input valid, divisor, weight, last, output ready);
endinterface

`default_nettype wire

/* rtl/bds_out_if.sv */
// ----------------------------------------------------------------------------
// bds_out_if
// Result channel: best divisor of one scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bds_out_if import bds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [TT_W-1:0]  best_function;
	logic [IDX_W-1:0] best_index;
	logic [WGT_W-1:0] best_weight;
	cost_t            best_cost;

	modport source (output valid, found, best_function, best_index, best_weight,
		best_cost, input ready);
	modport sink   (input valid, found, best_function, best_index, best_weight,
		best_cost, output ready);
endinterface

`default_nettype wire

/* rtl/best_divisor_select_core.sv */
// ----------------------------------------------------------------------------
// best_divisor_select_core
// Picks the best-scoring divisor of a scan against the off-set and on-set.
// ----------------------------------------------------------------------------
// Usage:
//  - Write off_set (0x0) and on_set (0x8) over APB while the block is idle.
//  - Stream divisors on cand (valid/ready); mark the final one with last.
//  - Each scan yields one transaction on result: found flag, winning truth
//    table (complemented when a complement check won), index, weight, cost.
// Timing:
//  - One divisor per cycle while result is not stalled; the path per item
//    is an input register, a scoring stage (four 64-bit popcounts) and the
//    running-best compare feeding the result register.
//  - The last divisor sets the result register from the running-best stage.
// Reset clears the running best, the item counter, both set registers and
// empties the pipeline. If result is stalled, the pipeline keeps taking
// divisors until a second last item reaches the running-best stage; it then
// holds and cand.ready drops until the result transaction completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module best_divisor_select_core import bds_pkg::*; #(
	parameter int unsigned MAX_DIVISORS = 16777216
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	bds_in_if.sink             cand,
	bds_out_if.source          result
);

	localparam longint unsigned IDX_SPAN = longint'(1) << IDX_W;
	localparam longint unsigned WRAP_AT  =
		(longint'(MAX_DIVISORS) < IDX_SPAN) ? longint'(MAX_DIVISORS) : IDX_SPAN;

	logic [TT_W-1:0]  off_set;
	logic [TT_W-1:0]  on_set;

	logic             in_ready;
	logic             in_acc;
	logic [IDX_W-1:0] count_q;
	logic [IDX_W:0]   count_nxt;

	logic             valid_s1;
	logic [TT_W-1:0]  divisor_s1;
	logic [WGT_W-1:0] weight_s1;
	logic [IDX_W-1:0] index_s1;
	logic             last_s1;

	logic             s2_free;
	logic             valid_s2;
	cand_t            cand_s2;
	logic             taken;

	bds_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.off_set (off_set),
		.on_set  (on_set)
	);

	assign in_ready   = !valid_s1 || s2_free;
	assign cand.ready = in_ready;
	assign in_acc     = cand.valid && in_ready;
	assign count_nxt  = {1'b0, count_q} + (IDX_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= cand.valid;
			end
			if (in_acc) begin
				if (cand.last || (count_nxt >= (IDX_W+1)'(WRAP_AT))) begin
					count_q <= '0;
				end else begin
					count_q <= count_nxt[IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			divisor_s1 <= cand.divisor;
			weight_s1  <= cand.weight;
			last_s1    <= cand.last;
			index_s1   <= count_q;
		end
	end

	bds_score u_score (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.divisor_s1 (divisor_s1),
		.weight_s1  (weight_s1),
		.index_s1   (index_s1),
		.last_s1    (last_s1),
		.off_set    (off_set),
		.on_set     (on_set),
		.taken      (taken),
		.s2_free    (s2_free),
		.valid_s2   (valid_s2),
		.cand_s2    (cand_s2)
	);

	bds_best u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.cand_s2  (cand_s2),
		.taken    (taken),
		.result   (result)
	);

endmodule

`default_nettype wire

/* rtl/bds_cfg.sv */
// ----------------------------------------------------------------------------
// bds_cfg
// APB register file holding the off-set and on-set minterm tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bds_cfg import bds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	output logic [TT_W-1:0]    off_set,
	output logic [TT_W-1:0]    on_set
);

	logic            reg_sel;
	logic            wr_en;
	logic [TT_W-1:0] off_set_q;
	logic [TT_W-1:0] on_set_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_set_q <= '0;
			on_set_q  <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_OFF_SET: off_set_q <= pwdata;
				REG_ON_SET:  on_set_q  <= pwdata;
				default:     off_set_q <= off_set_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_OFF_SET: prdata = off_set_q;
			REG_ON_SET:  prdata = on_set_q;
			default:     prdata = '0;
		endcase
	end

	assign off_set = off_set_q;
	assign on_set  = on_set_q;

endmodule

`default_nettype wire

/* rtl/bds_score.sv */
// ----------------------------------------------------------------------------
// bds_score
// Runs the four disjointness checks on one divisor, scores them and keeps
// the first best passing check in the stage-2 register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bds_score import bds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  logic [TT_W-1:0]  divisor_s1,
	input  logic [WGT_W-1:0] weight_s1,
	input  logic [IDX_W-1:0] index_s1,
	input  logic             last_s1,
	input  logic [TT_W-1:0]  off_set,
	input  logic [TT_W-1:0]  on_set,
	input  logic             taken,
	output logic             s2_free,
	output logic             valid_s2,
	output cand_t            cand_s2
);

	logic [TT_W-1:0] inv_div;
	logic [TT_W-1:0] cov    [N_CHECK];
	logic [TT_W-1:0] fn_k   [N_CHECK];
	logic            pass_k [N_CHECK];
	cost_t           sc_k   [N_CHECK];
	logic            pick_ok;
	cost_t           pick_score;
	logic [TT_W-1:0] pick_fn;

	assign inv_div = ~divisor_s1;

	// check order matters: earlier checks win ties
	always_comb begin
		pass_k[0] = (divisor_s1 & off_set) == '0;
		cov[0]    = divisor_s1 & on_set;
		fn_k[0]   = divisor_s1;
		pass_k[1] = (divisor_s1 & on_set) == '0;
		cov[1]    = divisor_s1 & off_set;
		fn_k[1]   = divisor_s1;
		pass_k[2] = (inv_div & off_set) == '0;
		cov[2]    = inv_div & on_set;
		fn_k[2]   = inv_div;
		pass_k[3] = (inv_div & on_set) == '0;
		cov[3]    = inv_div & off_set;
		fn_k[3]   = inv_div;
		for (int k = 0; k < N_CHECK; k++) begin
			sc_k[k] = score_of(pop64(cov[k]), weight_s1);
		end
	end

	always_comb begin
		pick_ok    = 1'b0;
		pick_score = COST_NONE;
		pick_fn    = divisor_s1;
		for (int k = 0; k < N_CHECK; k++) begin
			if (pass_k[k] && (!pick_ok || (sc_k[k] > pick_score))) begin
				pick_ok    = 1'b1;
				pick_score = sc_k[k];
				pick_fn    = fn_k[k];
			end
		end
	end

	assign s2_free = !valid_s2 || taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			cand_s2.last   <= last_s1;
			cand_s2.ok     <= pick_ok;
			cand_s2.score  <= pick_score;
			cand_s2.fn     <= pick_fn;
			cand_s2.index  <= index_s1;
			cand_s2.weight <= weight_s1;
		end
	end

endmodule

`default_nettype wire

/* rtl/bds_best.sv */
// ----------------------------------------------------------------------------
// bds_best
// Running best of the scan and the result register of the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bds_best import bds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	input  cand_t      cand_s2,
	output logic       taken,
	bds_out_if.source  result
);

	cost_t            best_cost_q;
	logic [TT_W-1:0]  best_fn_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [WGT_W-1:0] best_wgt_q;

	logic             res_valid_q;
	logic             found_q;
	cost_t            res_cost_q;
	logic [TT_W-1:0]  res_fn_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [WGT_W-1:0] res_wgt_q;

	logic             out_free;
	logic             win;
	logic             close_scan;
	cost_t            mrg_cost;
	logic [TT_W-1:0]  mrg_fn;
	logic [IDX_W-1:0] mrg_idx;
	logic [WGT_W-1:0] mrg_wgt;

	assign out_free   = !res_valid_q || result.ready;
	// a last item waits only if the result register is still occupied
	assign taken      = valid_s2 && (!cand_s2.last || out_free);
	assign close_scan = taken && cand_s2.last;
	assign win        = cand_s2.ok && (cand_s2.score > best_cost_q);

	always_comb begin
		mrg_cost = win ? cand_s2.score  : best_cost_q;
		mrg_fn   = win ? cand_s2.fn     : best_fn_q;
		mrg_idx  = win ? cand_s2.index  : best_idx_q;
		mrg_wgt  = win ? cand_s2.weight : best_wgt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_cost_q <= COST_NONE;
			best_fn_q   <= '0;
			best_idx_q  <= '0;
			best_wgt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (close_scan) begin
				best_cost_q <= COST_NONE;
				best_fn_q   <= '0;
				best_idx_q  <= '0;
				best_wgt_q  <= '0;
			end else if (taken) begin
				best_cost_q <= mrg_cost;
				best_fn_q   <= mrg_fn;
				best_idx_q  <= mrg_idx;
				best_wgt_q  <= mrg_wgt;
			end
			if (close_scan) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close_scan) begin
			found_q    <= mrg_cost > COST_NONE;
			res_cost_q <= mrg_cost;
			res_fn_q   <= mrg_fn;
			res_idx_q  <= mrg_idx;
			res_wgt_q  <= mrg_wgt;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.found         = found_q;
	assign result.best_function = res_fn_q;
	assign result.best_index    = res_idx_q;
	assign result.best_weight   = res_wgt_q;
	assign result.best_cost     = res_cost_q;

endmodule

`default_nettype wire

/* rtl/bds_chk.sv */
// ----------------------------------------------------------------------------
// bds_chk
// Port-level checks on the result channel of the divisor selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "best_divisor_select_core_assert.svh"

module bds_chk import bds_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             found,
	input logic [TT_W-1:0]  best_function,
	input logic [IDX_W-1:0] best_index,
	input logic [WGT_W-1:0] best_weight,
	input cost_t            best_cost
);

	// found agrees with the cost sign; no find means cost of -1
	`BDS_ASSERT_IMP(a_found_cost, clk, arst_n, out_valid, ((found == !best_cost[COST_W-1]) && (found || (best_cost == COST_NONE))), "found flag disagrees with best_cost")

	// an empty scan reports cleared fields
	`BDS_ASSERT_IMP(a_empty_fields, clk, arst_n, (out_valid && !found), ((best_function == '0) && (best_index == '0) && (best_weight == '0)), "empty scan with nonzero fields")

	// cost never exceeds 64 covered minterms at weight zero
	`BDS_ASSERT_IMP(a_cost_max, clk, arst_n, out_valid, (best_cost <= 11'sd528), "best_cost above maximum")

	`BDS_ASSERT_NXT(a_hold, clk, arst_n, (out_valid && !out_ready), (out_valid && $stable(best_function) && $stable(best_cost) && $stable(best_index) && $stable(best_weight) && $stable(found)), "stalled result changed")

endmodule

bind best_divisor_select_core bds_chk u_bds_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.found         (result.found),
	.best_function (result.best_function),
	.best_index    (result.best_index),
	.best_weight   (result.best_weight),
	.best_cost     (result.best_cost)
);

`default_nettype wire
